// ===== rtl/rexb_pkg.sv =====
// rexb_pkg: shared types and constants for the roi expand bounds check block
// no dependencies; imported by rexb_prep, rexb_scale and roi_expand_bounds_check
`timescale 1ns / 1ps

package rexb_pkg;

    // register field widths that do not vary
    localparam int IMG_BITS  = 12;
    localparam int MODE_BITS = 4;

    // ratio is unsigned q.12, this code means 1.0
    localparam int RATIO_ONE      = 4096;
    localparam int RATIO_ONE_BITS = 13;

    // fixed point alignment shifts
    localparam int Q4_TO_Q8   = 4;   // edge q.4 to length q.8
    localparam int RAD_SHIFT  = 8;   // q.8 sum of squares to q.16 radicand
    localparam int Q4_TO_Q20  = 16;  // q.4 to q.20
    localparam int IMG_TO_Q20 = 21;  // whole pixels to twice q.20

    // reset values of the configuration registers
    localparam int RESET_IMG_W = 1920;
    localparam int RESET_IMG_H = 1080;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCALE_RATIO  = 2'd0,
        CFG_SCALE_MODE   = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } cfg_index_t;

    // scale modes; codes above MODE_NONE always pass
    typedef enum logic [MODE_BITS-1:0] {
        MODE_WLEN       = 4'd0,
        MODE_WRATIO     = 4'd1,
        MODE_HRATIO     = 4'd2,
        MODE_LSIDE_RAT  = 4'd3,
        MODE_HLEN       = 4'd4,
        MODE_LSIDE_LEN  = 4'd5,
        MODE_LSIDE_SQ   = 4'd6,
        MODE_DIAG_SQ    = 4'd7,
        MODE_NONE       = 4'd8
    } scale_mode_t;

    // mode control handed from the register bank to the scale stages
    typedef struct packed {
        scale_mode_t mode;
        logic        bypass;  // unit ratio or unknown mode: always pass
    } mode_ctrl_t;

endpackage

// ===== rtl/roi_expand_bounds_check.sv =====
// roi_expand_bounds_check: top level, register bank, pipeline and output skid
// depends on rexb_pkg, rexb_prep, rexb_isqrt and rexb_scale
`timescale 1ns / 1ps

// Checks whether a box, rescaled about its center by scale_ratio in the
// way scale_mode selects, stays a proper box inside the configured image;
// expand_fails is 1 when it does not. One request is accepted per cycle
// while in_stall is low. Three stages form size, center and squared
// diagonal, the square root takes one stage per result bit (COORD_BITS
// + 5 stages), three stages scale and test the bounds, and one output
// register follows. When the output is held off, one further result
// lands in a skid register and in_stall rises the cycle after; it falls
// once the output is taken again. Registers are written through the
// cfg port, which is always ready; the user must write them only while
// no request is in flight, as the block itself does not enforce this.

module roi_expand_bounds_check #(
    parameter int COORD_BITS = 16,
    parameter int RATIO_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] box_left,
    input  logic [COORD_BITS-1:0] box_top,
    input  logic [COORD_BITS-1:0] box_right,
    input  logic [COORD_BITS-1:0] box_bottom,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  expand_fails,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  rexb_pkg::cfg_index_t  cfg_index,
    input  logic [((RATIO_BITS > rexb_pkg::IMG_BITS) ? RATIO_BITS : rexb_pkg::IMG_BITS)-1:0]
                                  cfg_data
);

    import rexb_pkg::*;

    localparam int RX     = (RATIO_BITS > RATIO_ONE_BITS) ? RATIO_BITS : RATIO_ONE_BITS;
    localparam int RAD_W  = 2 * COORD_BITS + 10;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SIDE_W = 4 * (COORD_BITS + 1);

    // configuration registers
    logic [RATIO_BITS-1:0] scale_ratio_reg;
    scale_mode_t           scale_mode_reg;
    logic [IMG_BITS-1:0]   image_width_reg;
    logic [IMG_BITS-1:0]   image_height_reg;
    mode_ctrl_t            mode_ctrl;

    // pipeline links
    logic                  en;
    logic                  prep_valid;
    logic [RAD_W-1:0]      prep_rad;
    logic [SIDE_W-1:0]     prep_side;
    logic                  sqrt_valid;
    logic [ROOT_W-1:0]     sqrt_root;
    logic [SIDE_W-1:0]     sqrt_side;
    logic                  tail_valid;
    logic                  tail_fail;

    // output and skid registers
    logic out_valid_reg;
    logic out_valid_next;
    logic fail_reg;
    logic fail_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic skid_fail_reg;
    logic skid_fail_next;
    logic take;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_ratio_reg  <= RATIO_BITS'(RATIO_ONE);
            scale_mode_reg   <= MODE_NONE;
            image_width_reg  <= IMG_BITS'(RESET_IMG_W);
            image_height_reg <= IMG_BITS'(RESET_IMG_H);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCALE_RATIO:  scale_ratio_reg  <= cfg_data[RATIO_BITS-1:0];
                CFG_SCALE_MODE:   scale_mode_reg   <= scale_mode_t'(cfg_data[MODE_BITS-1:0]);
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_BITS-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_BITS-1:0];
                default:          scale_ratio_reg  <= scale_ratio_reg;
            endcase
        end
    end

    // unit ratio and unknown mode codes always pass
    assign mode_ctrl.mode   = scale_mode_reg;
    assign mode_ctrl.bypass = (RX'(scale_ratio_reg) == RX'(RATIO_ONE))
                           || (MODE_BITS'(scale_mode_reg) > MODE_BITS'(MODE_NONE));

    // whole pipeline moves unless the skid register is full
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    rexb_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_right  (box_right),
        .box_bottom (box_bottom),
        .out_valid  (prep_valid),
        .rad        (prep_rad),
        .side       (prep_side)
    );

    rexb_isqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .rad       (prep_rad),
        .side_in   (prep_side),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .side_out  (sqrt_side)
    );

    rexb_scale #(
        .COORD_BITS (COORD_BITS),
        .RATIO_BITS (RATIO_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .root      (sqrt_root),
        .side      (sqrt_side),
        .ratio     (scale_ratio_reg),
        .mode_ctrl (mode_ctrl),
        .img_w     (image_width_reg),
        .img_h     (image_height_reg),
        .out_valid (tail_valid),
        .fail      (tail_fail)
    );

    // output register with one skid entry behind it
    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        fail_next       = fail_reg;
        skid_valid_next = skid_valid_reg;
        skid_fail_next  = skid_fail_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                fail_next       = skid_fail_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (tail_valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                fail_next      = tail_fail;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_fail_next  = tail_fail;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fail_reg      <= fail_next;
        skid_fail_reg <= skid_fail_next;
    end

    assign out_valid    = out_valid_reg;
    assign expand_fails = fail_reg;

endmodule

// ===== rtl/rexb_prep.sv =====
// rexb_prep: box size, doubled center and squared diagonal, three stages
// depends on rexb_pkg; feeds rexb_isqrt inside roi_expand_bounds_check
`timescale 1ns / 1ps

module rexb_prep #(
    parameter int COORD_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [COORD_BITS-1:0]     box_left,
    input  logic [COORD_BITS-1:0]     box_top,
    input  logic [COORD_BITS-1:0]     box_right,
    input  logic [COORD_BITS-1:0]     box_bottom,
    output logic                      out_valid,
    output logic [2*COORD_BITS+9:0]   rad,
    output logic [4*COORD_BITS+3:0]   side
);

    import rexb_pkg::*;

    localparam int CW     = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int RAD_W  = 2 * COORD_BITS + 10;
    localparam int SIDE_W = 4 * CW;

    logic [2:0] valid_reg;
    logic [2:0] valid_next;

    logic signed [CW-1:0] w_reg;
    logic signed [CW-1:0] h_reg;
    logic [CW-1:0]        cx_reg;
    logic [CW-1:0]        cy_reg;
    logic signed [CW-1:0] w_next;
    logic signed [CW-1:0] h_next;
    logic [CW-1:0]        cx_next;
    logic [CW-1:0]        cy_next;

    logic signed [2*CW-1:0] ww_full;
    logic signed [2*CW-1:0] hh_full;
    logic [SQ_W-1:0]        ww_reg;
    logic [SQ_W-1:0]        hh_reg;
    logic [SIDE_W-1:0]      side2_reg;

    logic [RAD_W-1:0]  rad_reg;
    logic [RAD_W-1:0]  rad_next;
    logic [SIDE_W-1:0] side3_reg;

    // stage 1: signed size and twice the center
    assign w_next  = $signed({1'b0, box_right})  - $signed({1'b0, box_left});
    assign h_next  = $signed({1'b0, box_bottom}) - $signed({1'b0, box_top});
    assign cx_next = CW'(box_left) + CW'(box_right);
    assign cy_next = CW'(box_top)  + CW'(box_bottom);

    // stage 2: squares of the size
    assign ww_full = w_reg * w_reg;
    assign hh_full = h_reg * h_reg;

    // stage 3: radicand in q.16
    assign rad_next = (RAD_W'(ww_reg) + RAD_W'(hh_reg)) << RAD_SHIFT;

    assign valid_next = {valid_reg[1:0], in_valid & en};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= w_next;
            h_reg     <= h_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            ww_reg    <= SQ_W'(ww_full);
            hh_reg    <= SQ_W'(hh_full);
            side2_reg <= {w_reg, h_reg, cx_reg, cy_reg};
            rad_reg   <= rad_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign rad       = rad_reg;
    assign side      = side3_reg;

endmodule

// ===== rtl/rexb_isqrt.sv =====
// rexb_isqrt: pipelined integer square root, one result bit per stage
// no package dependency; carries a sideband word alongside each request
`timescale 1ns / 1ps

module rexb_isqrt #(
    parameter int RAD_W  = 42,
    parameter int SIDE_W = 68
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [RAD_W-1:0]      rad,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [RAD_W/2-1:0]    root,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int STAGES = RAD_W / 2;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [RAD_W-1:0]  rem_reg  [STAGES];
    logic [RAD_W-1:0]  rem_next [STAGES];
    logic [RAD_W-1:0]  res_reg  [STAGES];
    logic [RAD_W-1:0]  res_next [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];

    assign valid_next = {valid_reg[STAGES-2:0], in_valid};

    // one trial subtraction per stage, weight falls by four each stage
    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam logic [RAD_W:0] WEIGHT = (RAD_W+1)'(1) << (2 * (STAGES - 1 - k));

        logic [RAD_W-1:0] rem_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W:0]   trial;
        logic             fits;

        if (k == 0)
        begin : g_first
            assign rem_in = rad;
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial       = {1'b0, res_in} + WEIGHT;
        assign fits        = {1'b0, rem_in} >= trial;
        assign rem_next[k] = fits ? RAD_W'({1'b0, rem_in} - trial) : rem_in;
        assign res_next[k] = fits ? RAD_W'(({1'b0, res_in} >> 1) + WEIGHT)
                                  : (res_in >> 1);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // remainder, partial root and sideband per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
            end
            side_reg[0] <= side_in;
            for (int k = 1; k < STAGES; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign root      = res_reg[STAGES-1][STAGES-1:0];
    assign side_out  = side_reg[STAGES-1];

endmodule

// ===== rtl/rexb_scale.sv =====
// rexb_scale: new size from the ratio, degenerate test and image bounds test
// depends on rexb_pkg; three stages after the square root
`timescale 1ns / 1ps

module rexb_scale #(
    parameter int COORD_BITS = 16,
    parameter int RATIO_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [COORD_BITS+4:0]         root,
    input  logic [4*COORD_BITS+3:0]       side,
    input  logic [RATIO_BITS-1:0]         ratio,
    input  rexb_pkg::mode_ctrl_t          mode_ctrl,
    input  logic [rexb_pkg::IMG_BITS-1:0] img_w,
    input  logic [rexb_pkg::IMG_BITS-1:0] img_h,
    output logic                          out_valid,
    output logic                          fail
);

    import rexb_pkg::*;

    localparam int CW    = COORD_BITS + 1;
    localparam int LB    = COORD_BITS + 6;
    localparam int RX    = (RATIO_BITS > RATIO_ONE_BITS) ? RATIO_BITS : RATIO_ONE_BITS;
    localparam int PW    = LB + RX + 1;
    localparam int SUM_A = COORD_BITS + RX + 10;
    localparam int SUM_B = COORD_BITS + 20;
    localparam int SUM_0 = (SUM_A > SUM_B) ? SUM_A : SUM_B;
    localparam int SUM_W = (SUM_0 > 36) ? SUM_0 : 36;

    logic [2:0] valid_reg;
    logic [2:0] valid_next;

    // unpacked sideband
    logic signed [CW-1:0] w_s;
    logic signed [CW-1:0] h_s;
    logic [CW-1:0]        cx_s;
    logic [CW-1:0]        cy_s;

    assign w_s  = side[4*CW-1 -: CW];
    assign h_s  = side[3*CW-1 -: CW];
    assign cx_s = side[2*CW-1 -: CW];
    assign cy_s = side[CW-1:0];

    // stage 1 signals
    logic                 gt_next;
    logic signed [CW-1:0] big_s;
    logic signed [LB-1:0] len_a;
    logic signed [LB-1:0] len_b;
    logic [RX-1:0]        r_eff;
    logic signed [RX:0]   r_s;
    logic signed [PW-1:0] prod_a_next;
    logic signed [PW-1:0] prod_b_next;

    logic signed [PW-1:0] prod_a_reg;
    logic signed [PW-1:0] prod_b_reg;
    logic signed [CW-1:0] w1_reg;
    logic signed [CW-1:0] h1_reg;
    logic [CW-1:0]        cx1_reg;
    logic [CW-1:0]        cy1_reg;
    logic                 gt1_reg;

    // stage 2 signals
    logic signed [SUM_W-1:0] w20;
    logic signed [SUM_W-1:0] h20;
    logic signed [SUM_W-1:0] wn_next;
    logic signed [SUM_W-1:0] hn_next;
    logic                    degen_next;

    logic signed [SUM_W-1:0] wn_reg;
    logic signed [SUM_W-1:0] hn_reg;
    logic                    degen_reg;
    logic [CW-1:0]           cx2_reg;
    logic [CW-1:0]           cy2_reg;

    // stage 3 signals
    logic signed [SUM_W-1:0] cx20;
    logic signed [SUM_W-1:0] cy20;
    logic signed [SUM_W-1:0] iw;
    logic signed [SUM_W-1:0] ih;
    logic signed [SUM_W-1:0] edge_l;
    logic signed [SUM_W-1:0] edge_r;
    logic signed [SUM_W-1:0] edge_t;
    logic signed [SUM_W-1:0] edge_b;
    logic                    outside;
    logic                    fail_next;
    logic                    fail_reg;

    // stage 1: pick the lengths in q.8 and multiply by the ratio
    assign gt_next = w_s > h_s;
    assign big_s   = gt_next ? w_s : h_s;
    assign r_eff   = (mode_ctrl.mode == MODE_NONE) ? RX'(RATIO_ONE) : RX'(ratio);
    assign r_s     = {1'b0, r_eff};

    always_comb
    begin
        case (mode_ctrl.mode)
            MODE_LSIDE_SQ:
            begin
                len_a = LB'(big_s) << Q4_TO_Q8;
                len_b = LB'(big_s) << Q4_TO_Q8;
            end
            MODE_DIAG_SQ:
            begin
                len_a = LB'(root);
                len_b = LB'(root);
            end
            default:
            begin
                len_a = LB'(w_s) << Q4_TO_Q8;
                len_b = LB'(h_s) << Q4_TO_Q8;
            end
        endcase
    end

    assign prod_a_next = len_a * r_s;
    assign prod_b_next = len_b * r_s;

    // stage 2: new width and height in q.20, length modes shift the other side by the same change
    assign w20 = SUM_W'(w1_reg) << Q4_TO_Q20;
    assign h20 = SUM_W'(h1_reg) << Q4_TO_Q20;

    always_comb
    begin
        wn_next    = SUM_W'(prod_a_reg);
        hn_next    = SUM_W'(prod_b_reg);
        degen_next = 1'b0;
        case (mode_ctrl.mode)
            MODE_WLEN:
            begin
                hn_next    = h20 + SUM_W'(prod_a_reg) - w20;
                degen_next = hn_next <= 0;
            end
            MODE_HLEN:
            begin
                wn_next    = w20 + SUM_W'(prod_b_reg) - h20;
                degen_next = wn_next <= 0;
            end
            MODE_LSIDE_LEN:
            begin
                if (gt1_reg)
                begin
                    hn_next    = h20 + SUM_W'(prod_a_reg) - w20;
                    degen_next = hn_next <= 0;
                end
                else
                begin
                    wn_next    = w20 + SUM_W'(prod_b_reg) - h20;
                    degen_next = wn_next <= 0;
                end
            end
            default:
            begin
                degen_next = 1'b0;
            end
        endcase
    end

    // stage 3: edges in twice q.20 against the image
    assign cx20   = SUM_W'(cx2_reg) << Q4_TO_Q20;
    assign cy20   = SUM_W'(cy2_reg) << Q4_TO_Q20;
    assign iw     = SUM_W'(img_w) << IMG_TO_Q20;
    assign ih     = SUM_W'(img_h) << IMG_TO_Q20;
    assign edge_l = cx20 - wn_reg;
    assign edge_r = cx20 + wn_reg;
    assign edge_t = cy20 - hn_reg;
    assign edge_b = cy20 + hn_reg;

    assign outside   = (edge_l < 0) || (edge_t < 0) || (edge_r > iw) || (edge_b > ih);
    assign fail_next = !mode_ctrl.bypass && (degen_reg || outside);

    assign valid_next = {valid_reg[1:0], in_valid};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            w1_reg     <= w_s;
            h1_reg     <= h_s;
            cx1_reg    <= cx_s;
            cy1_reg    <= cy_s;
            gt1_reg    <= gt_next;
            wn_reg     <= wn_next;
            hn_reg     <= hn_next;
            degen_reg  <= degen_next;
            cx2_reg    <= cx1_reg;
            cy2_reg    <= cy1_reg;
            fail_reg   <= fail_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign fail      = fail_reg;

endmodule

// ===== rtl/rexb_checker.sv =====
// rexb_checker: port-level checks of the output register and skid behavior
// no package dependency; bound to roi_expand_bounds_check below
`timescale 1ns / 1ps

module rexb_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic expand_fails
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(expand_fails))
        else $error("held result changed");

    // input stalls only after a result was held off
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without a held result");

    // a full skid entry implies a waiting result
    a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result shown");

    // skid entry drains on the first free output cycle
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall)
        else $error("input stall held after output freed");

    // a blocked request always has a result waiting
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |-> out_valid)
        else $error("request blocked with empty output");

endmodule

bind roi_expand_bounds_check rexb_checker u_rexb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .expand_fails (expand_fails)
);

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for roi_expand_bounds_check (rescaled box bounds flag)
// depends on rexb_pkg and the roi_expand_bounds_check rtl; predicts each flag in-bench
`timescale 1ns / 1ps

module tb_top;
    import rexb_pkg::*;

    localparam int COORD_W      = 16;
    localparam int CFG_W        = 16;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_PAUSE  = 40;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 36;
    localparam int PHASE_BOXES  = 50;

    // q.4 edge times q.12 ratio is q.16; this factor lifts it to q.20
    localparam longint RATIO_TO_Q20     = longint'(1) << (Q4_TO_Q20 - 12);
    localparam longint Q20_PER_Q4       = longint'(1) << Q4_TO_Q20;
    localparam longint TWICE_Q20_PER_PX = longint'(1) << IMG_TO_Q20;

    // mode codes past the named ones, all of which must pass
    localparam logic [MODE_BITS-1:0] MODE_UNKNOWN_LO = MODE_BITS'(MODE_NONE + 1);
    localparam logic [MODE_BITS-1:0] MODE_CODE_MAX   = '1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [COORD_W-1:0] box_left = '0;
    logic [COORD_W-1:0] box_top = '0;
    logic [COORD_W-1:0] box_right = '0;
    logic [COORD_W-1:0] box_bottom = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               expand_fails;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index = CFG_SCALE_RATIO;
    logic [CFG_W-1:0]   cfg_data = '0;

    typedef struct {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic               fails;
    } box_flag_t;

    // flags still owed by the block, oldest first
    box_flag_t pending_flags[$];

    // bench copy of the register bank
    logic [CFG_W-1:0]     cur_ratio;
    logic [MODE_BITS-1:0] cur_mode;
    logic [IMG_BITS-1:0]  cur_img_w;
    logic [IMG_BITS-1:0]  cur_img_h;

    bit sender_gaps     = 1'b0;
    bit receiver_stalls = 1'b0;
    bit hold_request    = 1'b0;
    int error_count     = 0;

    roi_expand_bounds_check #(
        .COORD_BITS(COORD_W),
        .RATIO_BITS(CFG_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .box_left(box_left),
        .box_top(box_top),
        .box_right(box_right),
        .box_bottom(box_bottom),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .expand_fails(expand_fails),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // idle stretch: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COORD_W-1:0] q4(input int px);
        return COORD_W'(px << 4);
    endfunction

    // floor of the square root, one result bit at a time from the top
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (longint'(1) << i);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // flag for one box under the current registers; all lengths in q.20
    function automatic logic expanded_box_fails(input logic [COORD_W-1:0] x1_q4, y1_q4,
                                                input logic [COORD_W-1:0] x2_q4, y2_q4);
        longint x1, y1, x2, y2, r, w, h, w20, h20, wn, hn, cx2, cy2, iw, ih;
        longint unsigned diag;
        logic fail;
        x1 = x1_q4;
        y1 = y1_q4;
        x2 = x2_q4;
        y2 = y2_q4;
        r = cur_ratio;
        fail = 1'b0;
        if (cur_ratio == RATIO_ONE || cur_mode > MODE_NONE)
            return 1'b0;
        w = x2 - x1;
        h = y2 - y1;
        w20 = w * Q20_PER_Q4;
        h20 = h * Q20_PER_Q4;
        wn = w20;
        hn = h20;

        // width leads, height follows by the same length change
        if (cur_mode == MODE_WLEN || (cur_mode == MODE_LSIDE_LEN && w > h))
        begin
            wn = w * r * RATIO_TO_Q20;
            hn = h20 + wn - w20;
            fail = (hn <= 0);
        end
        // height leads, width follows
        else if (cur_mode == MODE_HLEN || cur_mode == MODE_LSIDE_LEN)
        begin
            hn = h * r * RATIO_TO_Q20;
            wn = w20 + hn - h20;
            fail = (wn <= 0);
        end
        else if (cur_mode == MODE_WRATIO || cur_mode == MODE_HRATIO
                 || cur_mode == MODE_LSIDE_RAT)
        begin
            wn = w * r * RATIO_TO_Q20;
            hn = h * r * RATIO_TO_Q20;
        end
        else if (cur_mode == MODE_LSIDE_SQ)
        begin
            wn = ((w > h) ? w : h) * r * RATIO_TO_Q20;
            hn = wn;
        end
        // diagonal in q.8, truncated
        else if (cur_mode == MODE_DIAG_SQ)
        begin
            diag = floor_sqrt((w * w + h * h) << RAD_SHIFT);
            wn = diag * r;
            hn = wn;
        end

        // edges around twice the center against twice the image size
        if (!fail)
        begin
            cx2 = (x1 + x2) * Q20_PER_Q4;
            cy2 = (y1 + y2) * Q20_PER_Q4;
            iw = cur_img_w;
            ih = cur_img_h;
            iw = iw * TWICE_Q20_PER_PX;
            ih = ih * TWICE_Q20_PER_PX;
            fail = (cx2 - wn < 0) || (cy2 - hn < 0) || (cx2 + wn > iw) || (cy2 + hn > ih);
        end
        return fail;
    endfunction

    // offer one box request, hold it until taken, then log its flag
    task automatic send_box(input logic [COORD_W-1:0] x1, y1, x2, y2);
        box_flag_t entry;
        int gap;
        gap = sender_gaps ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        box_left   <= x1;
        box_top    <= y1;
        box_right  <= x2;
        box_bottom <= y2;
        entry.left   = x1;
        entry.top    = y1;
        entry.right  = x2;
        entry.bottom = y2;
        entry.fails  = expanded_box_fails(x1, y1, x2, y2);
        do
            @(posedge clk);
        while (in_stall);
        pending_flags.insert(pending_flags.size(), entry);
    endtask

    // mostly boxes near the image with random size, the rest raw noise
    task automatic send_random_box();
        int span_w, span_h, cx, cy, hw, hh, x1, y1, x2, y2, tmp;
        if ($urandom_range(0, 3) == 0)
        begin
            send_box(COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), COORD_W'($urandom));
        end
        else
        begin
            span_w = int'(cur_img_w) * 16;
            span_h = int'(cur_img_h) * 16;
            cx = $urandom_range(0, span_w);
            cy = $urandom_range(0, span_h);
            hw = $urandom_range(0, span_w / 4 + 16);
            hh = $urandom_range(0, span_h / 4 + 16);
            x1 = cx - hw;
            x2 = cx + hw;
            y1 = cy - hh;
            y2 = cy + hh;
            // occasionally inverted on either axis
            if ($urandom_range(0, 9) == 0)
            begin
                tmp = x1;
                x1 = x2;
                x2 = tmp;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                tmp = y1;
                y1 = y2;
                y2 = tmp;
            end
            send_box(COORD_W'(x1), COORD_W'(y1), COORD_W'(x2), COORD_W'(y2));
        end
    endtask

    // stop offering and let every flag come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // write all four registers, with junk above the mode and image field widths
    task automatic load_config(input logic [CFG_W-1:0] ratio, input logic [MODE_BITS-1:0] mode,
                               input logic [IMG_BITS-1:0] img_w, img_h);
        wait_all_results();
        write_reg(CFG_SCALE_RATIO, ratio);
        write_reg(CFG_SCALE_MODE, {(CFG_W - MODE_BITS)'($urandom), mode});
        write_reg(CFG_IMAGE_WIDTH, {(CFG_W - IMG_BITS)'($urandom), img_w});
        write_reg(CFG_IMAGE_HEIGHT, {(CFG_W - IMG_BITS)'($urandom), img_h});
        cfg_valid <= 1'b0;
        cur_ratio = ratio;
        cur_mode  = mode;
        cur_img_w = img_w;
        cur_img_h = img_h;
    endtask

    function automatic logic [IMG_BITS-1:0] pick_image_size();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return IMG_BITS'($urandom_range(16, 4095));
        endcase
    endfunction

    // unit ratio out of reset: even a box far outside passes
    task automatic test_reset_values();
        send_box('0, '0, '1, '1);
        send_box(q4(100), q4(100), q4(300), q4(200));
    endtask

    task automatic test_directed_modes();
        // every named mode at 1.5x: centered box on even codes, box at the left edge on odd
        for (int m = 0; m <= MODE_NONE; m++)
        begin
            load_config(16'd6144, MODE_BITS'(m), 12'd640, 12'd480);
            if (m % 2 == 0)
                send_box(q4(270), q4(210), q4(370), q4(270));
            else
                send_box(q4(10), q4(200), q4(110), q4(260));
        end

        // zero ratio collapses the leading side, the other side goes negative
        load_config('0, MODE_WLEN, 12'd640, 12'd480);
        send_box(q4(100), q4(100), q4(300), q4(110));
        load_config('0, MODE_HLEN, 12'd640, 12'd480);
        send_box(q4(100), q4(100), q4(110), q4(300));

        // inverted box keeps its negative size
        load_config(16'd8192, MODE_WRATIO, 12'd640, 12'd480);
        send_box(q4(400), q4(300), q4(200), q4(100));

        // unknown mode codes pass even when the box would leave the image
        load_config(16'd8192, MODE_UNKNOWN_LO, 12'd640, 12'd480);
        send_box('0, '0, q4(100), q4(100));
        load_config(16'd8192, MODE_CODE_MAX, 12'd640, 12'd480);
        send_box('0, '0, q4(100), q4(100));

        // unit ratio passes against an empty image
        load_config(CFG_W'(RATIO_ONE), MODE_LSIDE_SQ, '0, '0);
        send_box(q4(10), q4(10), q4(20), q4(20));

        // field and ratio extremes through the square root path
        load_config('1, MODE_DIAG_SQ, '1, '1);
        send_box('0, '0, '0, '0);
        send_box('1, '1, '1, '1);
        send_box('0, '0, '1, '1);
    endtask

    // receiver holds off long enough to fill the block and stall its input
    task automatic test_backpressure();
        load_config(16'd5120, MODE_LSIDE_SQ, 12'd1920, 12'd1080);
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        hold_request = 1'b1;
        repeat (80) send_random_box();
        // sender pauses until every flag is back, then a burst with random stalls
        wait_all_results();
        receiver_stalls = 1'b1;
        repeat (40) send_random_box();
    endtask

    task automatic test_random_configs();
        logic [CFG_W-1:0]     ratio;
        logic [MODE_BITS-1:0] mode;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 7))
                0: ratio = '0;
                1: ratio = '1;
                2: ratio = CFG_W'(RATIO_ONE);
                3: ratio = ($urandom_range(0, 1) == 0) ? CFG_W'(RATIO_ONE - 1)
                                                       : CFG_W'(RATIO_ONE + 1);
                default: ratio = CFG_W'($urandom_range(RATIO_ONE / 4, RATIO_ONE * 3));
            endcase
            // first phases walk the named modes, later ones draw at random
            if (phase < 2 * (MODE_NONE + 1))
                mode = MODE_BITS'(phase % (MODE_NONE + 1));
            else if ($urandom_range(0, 9) == 0)
                mode = MODE_BITS'($urandom_range(MODE_UNKNOWN_LO, MODE_CODE_MAX));
            else
                mode = MODE_BITS'($urandom_range(0, MODE_NONE));
            load_config(ratio, mode, pick_image_size(), pick_image_size());
            sender_gaps = (phase % 3 != 0);
            receiver_stalls = (phase % 4 != 1);
            repeat (PHASE_BOXES) send_random_box();
        end
    endtask

    // output side: random stall bursts plus the long hold on request
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (receiver_stalls)
                    stall_left = idle_len();
            end
        end
    end

    // compare each taken flag with the oldest one owed
    always @(posedge clk)
    begin
        box_flag_t entry;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_flags.size() == 0)
            begin
                $display("%0t: flag with no request pending: expected none, got %0b",
                         $time, expand_fails);
                error_count++;
            end
            else
            begin
                entry = pending_flags.pop_front();
                if (expand_fails !== entry.fails)
                begin
                    $display("%0t: box %h %h %h %h: expand_fails expected %0b, got %0b",
                             $time, entry.left, entry.top, entry.right, entry.bottom,
                             entry.fails, expand_fails);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        cur_ratio = CFG_W'(RATIO_ONE);
        cur_mode  = MODE_NONE;
        cur_img_w = IMG_BITS'(RESET_IMG_W);
        cur_img_h = IMG_BITS'(RESET_IMG_H);
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_modes();
        test_backpressure();
        test_random_configs();
        wait_all_results();

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== roi_expand_bounds_check.f =====
rtl/rexb_pkg.sv
rtl/rexb_prep.sv
rtl/rexb_isqrt.sv
rtl/rexb_scale.sv
rtl/roi_expand_bounds_check.sv
rtl/rexb_checker.sv
test/tb_top.sv
